/* rtl/core/pidfd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the filtered-derivative PID axis.
// Used by pidfd_div and pid_axis_filtered_derivative; depends on nothing.

package pidfd_pkg;

    // Width of the filtered derivative and its saturation range.
    localparam int DATA_WIDTH = 32;

    localparam int ERR_W    = 32;
    localparam int STEP_W   = 7;
    localparam int GAIN_W   = 16;
    localparam int ALPHA_W  = 17;
    localparam int INTEG_W  = 32;
    localparam int LIMIT_W  = 31;
    localparam int OUT_W    = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP    = 3'd0,
        REG_GAIN_INTEG   = 3'd1,
        REG_GAIN_DERIV   = 3'd2,
        REG_FILTER_ALPHA = 3'd3,
        REG_INTEG_MIN    = 3'd4,
        REG_INTEG_MAX    = 3'd5,
        REG_OUT_LIMIT    = 3'd6
    } cfg_reg_t;

    localparam logic [GAIN_W-1:0]         GAIN_PROP_RST  = 16'd5120;
    localparam logic [GAIN_W-1:0]         GAIN_INTEG_RST = 16'd246;
    localparam logic [GAIN_W-1:0]         GAIN_DERIV_RST = 16'd1147;
    localparam logic [ALPHA_W-1:0]        ALPHA_RST      = 17'd32768;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN_RST  = -32'sd10485760;
    localparam logic signed [INTEG_W-1:0] INTEG_MAX_RST  = 32'sd10485760;
    localparam logic [LIMIT_W-1:0]        OUT_LIMIT_RST  = 31'd26214400;

    localparam logic [STEP_W-1:0]  STEP_MIN  = STEP_W'(1);
    localparam logic [STEP_W-1:0]  STEP_MAX  = STEP_W'(100);
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

    // Fixed-point scaling.
    localparam int FRAC_GAIN  = 12;
    localparam int FRAC_ALPHA = 16;
    localparam int MS_PER_S   = 1000;
    // Integral increment divides by 4096 * 1000: shift by 12, then divide by 1000.
    localparam int INC_SHIFT  = 12;
    localparam int INC_HALF   = 4096 * 1000 / 2;

    // Shared multiplier operands and product.
    localparam int MA_W   = (DATA_WIDTH + 1 > ERR_W + 1) ? DATA_WIDTH + 1 : ERR_W + 1;
    localparam int MB_W   = GAIN_W + STEP_W;
    localparam int PROD_W = MA_W + MB_W;

    // Term widths (signed).
    localparam int P_W   = ERR_W + 5;
    localparam int D_W   = DATA_WIDTH + 5;
    localparam int INC_W = 36;
    localparam int ACC_W = INC_W + 1;
    localparam int SUM_W = ((P_W > D_W) ? P_W : D_W) + 2;

    // Serial divider: two quotient bits per cycle.
    localparam int DIVD_W    = 44;
    localparam int DIVS_W    = 10;
    localparam int DIV_STEPS = DIVD_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Saturation of the raw derivative quotient.
    localparam int SAT_W = ((DIVD_W > DATA_WIDTH) ? DIVD_W : DATA_WIDTH) + 1;
    localparam logic [SAT_W-1:0] RAW_NEG_MAG = SAT_W'(1) << (DATA_WIDTH - 1);
    localparam logic [SAT_W-1:0] RAW_POS_MAG = RAW_NEG_MAG - SAT_W'(1);
    localparam logic signed [DATA_WIDTH-1:0] RAW_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] RAW_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* rtl/core/pidfd_div.sv */
`timescale 1ns / 1ps
// Unsigned restoring divider, two quotient bits per cycle, floor quotient.
// Depends on pidfd_pkg for widths and the request/response structs.

module pidfd_div import pidfd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIVD_W-1:0]    quo_reg;
    logic [DIVS_W-1:0]    rem_reg;
    logic [DIVS_W-1:0]    div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIVS_W:0]   r1, r1s, r2, r2s;
    logic              ge1, ge2;
    logic [DIVD_W-1:0] quo_next;
    logic [DIVS_W-1:0] rem_next;

    always_comb begin
        r1       = {rem_reg, quo_reg[DIVD_W-1]};
        ge1      = (r1 >= {1'b0, div_reg});
        r1s      = ge1 ? (r1 - {1'b0, div_reg}) : r1;
        r2       = {r1s[DIVS_W-1:0], quo_reg[DIVD_W-2]};
        ge2      = (r2 >= {1'b0, div_reg});
        r2s      = ge2 ? (r2 - {1'b0, div_reg}) : r2;
        rem_next = r2s[DIVS_W-1:0];
        quo_next = {quo_reg[DIVD_W-3:0], ge1, ge2};
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end

        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !req.start && busy_reg && (cnt_reg == DIV_LAST);
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp = '{done: done_reg, quotient: quo_reg};

    // The partial remainder must stay below the divisor between steps.
    ap_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

    ap_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a preceding division");

    ap_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

/* rtl/core/pid_axis_filtered_derivative.sv */
`timescale 1ns / 1ps
// One PID axis step with a low-pass filtered derivative, top level.
// Depends on pidfd_pkg and pidfd_div.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_valid / s_ready    s_err_in, s_step_ms, s_clear_integ
//   m_       out        m_valid / m_ready    m_correction
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An input beat occupies the block from acceptance until the result beat is
// valid; s_ready returns in that same cycle. The time is set by two 44-bit
// divisions in the shared radix-4 divider, one for the raw derivative and one
// for the integral increment, plus the passes through the shared 33x23
// multiplier. Reset (aresetn, synchronous, active low) restores the register
// defaults and zeroes the integral, last error and filtered derivative. A
// result that is not taken holds the block in its final state; cfg_ready is
// always high.

module pid_axis_filtered_derivative import pidfd_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [ERR_W-1:0]  s_err_in,
    input  logic [STEP_W-1:0]        s_step_ms,
    input  logic                     s_clear_integ,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [OUT_W-1:0]  m_correction,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int DW = DATA_WIDTH;

    // The sequencer walks the terms in a fixed order. The multiplier takes new
    // operands every cycle; its operands and its product are registered, so a product
    // issued in one state passes mul_a_reg/mul_b_reg and then prod_reg before use.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P_MUL,
        ST_P_RND,
        ST_IGD,
        ST_RAW_DIV,
        ST_INC_NUM,
        ST_RAW_WAIT,
        ST_FILT_MUL,
        ST_FILT_WAIT,
        ST_FILT_RND,
        ST_D_MUL,
        ST_D_WAIT,
        ST_D_RND,
        ST_INC_WAIT,
        ST_OUT
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0]         gain_prop_reg;
    logic [GAIN_W-1:0]         gain_integ_reg;
    logic [GAIN_W-1:0]         gain_deriv_reg;
    logic [ALPHA_W-1:0]        filter_alpha_reg;
    logic signed [INTEG_W-1:0] integ_min_reg;
    logic signed [INTEG_W-1:0] integ_max_reg;
    logic [LIMIT_W-1:0]        out_limit_reg;

    assign cfg_ready = 1'b1;

    // Writes to an index past the register list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop_reg    <= GAIN_PROP_RST;
            gain_integ_reg   <= GAIN_INTEG_RST;
            gain_deriv_reg   <= GAIN_DERIV_RST;
            filter_alpha_reg <= ALPHA_RST;
            integ_min_reg    <= INTEG_MIN_RST;
            integ_max_reg    <= INTEG_MAX_RST;
            out_limit_reg    <= OUT_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GAIN_PROP:    gain_prop_reg    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_INTEG:   gain_integ_reg   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_DERIV:   gain_deriv_reg   <= cfg_data[GAIN_W-1:0];
                REG_FILTER_ALPHA: filter_alpha_reg <= cfg_data[ALPHA_W-1:0];
                REG_INTEG_MIN:    integ_min_reg    <= $signed(cfg_data[INTEG_W-1:0]);
                REG_INTEG_MAX:    integ_max_reg    <= $signed(cfg_data[INTEG_W-1:0]);
                REG_OUT_LIMIT:    out_limit_reg    <= cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath and sequencer registers
    // ------------------------------------------------------------------
    state_t                    state_reg, state_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic [ERR_W-1:0]          err_mag_reg, err_mag_next;
    logic [STEP_W-1:0]         dt_reg, dt_next;
    logic                      clr_reg, clr_next;
    logic                      diff_neg_reg, diff_neg_next;
    logic                      filt_neg_reg, filt_neg_next;
    logic [MA_W-1:0]           mul_a_reg, mul_a_next;
    logic [MB_W-1:0]           mul_b_reg, mul_b_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic signed [P_W-1:0]     p_reg, p_next;
    logic signed [D_W-1:0]     d_reg, d_next;
    logic signed [DW-1:0]      raw_reg, raw_next;
    logic [DIVD_W-1:0]         inc_num_reg, inc_num_next;
    logic signed [INTEG_W-1:0] integ_acc_reg, integ_acc_next;
    logic signed [ERR_W-1:0]   prev_err_reg, prev_err_next;
    logic signed [DW-1:0]      deriv_filt_reg, deriv_filt_next;
    logic                      m_valid_reg, m_valid_next;
    logic signed [OUT_W-1:0]   m_correction_reg, m_correction_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    pidfd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ------------------------------------------------------------------
    // Arithmetic around the shared units
    // ------------------------------------------------------------------
    logic [ERR_W-1:0]          err_mag_in;
    logic [STEP_W-1:0]         dt_in;
    logic [ALPHA_W-1:0]        alpha_eff;
    logic [PROD_W-1:0]         gain_rnd_sum;
    logic [PROD_W-1:0]         alpha_rnd_sum;
    logic [PROD_W-1:0]         inc_rnd_sum;
    logic [P_W-2:0]            p_mag;
    logic signed [P_W-1:0]     p_val;
    logic signed [ERR_W:0]     diff_s;
    logic [ERR_W:0]            diff_mag;
    logic [SAT_W-1:0]          quot_x;
    logic                      raw_ovf;
    logic signed [DW-1:0]      raw_val;
    logic signed [DW:0]        filt_diff;
    logic [DW:0]               filt_mag;
    logic [DW:0]               filt_step;
    logic signed [DW+1:0]      df_sum;
    logic                      df_ovf;
    logic signed [DW-1:0]      df_val;
    logic [DW-1:0]             df_mag;
    logic [D_W-2:0]            d_mag;
    logic signed [D_W-1:0]     d_val;
    logic signed [INC_W-1:0]   inc_val;
    logic signed [INTEG_W-1:0] integ_base;
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [INTEG_W-1:0] integ_val;
    logic signed [SUM_W-1:0]   pid_sum;
    logic signed [SUM_W-1:0]   lim_pos;
    logic signed [SUM_W-1:0]   lim_neg;
    logic signed [OUT_W-1:0]   out_val;

    assign prod_next = mul_a_reg * mul_b_reg;

    assign err_mag_in = s_err_in[ERR_W-1] ? ERR_W'(-s_err_in) : ERR_W'(s_err_in);
    assign dt_in = (s_step_ms < STEP_MIN) ? STEP_MIN :
                   (s_step_ms > STEP_MAX) ? STEP_MAX : s_step_ms;
    assign alpha_eff = (filter_alpha_reg > ALPHA_ONE) ? ALPHA_ONE : filter_alpha_reg;

    // All roundings work on magnitudes: add half an LSB, truncate, restore sign.
    assign gain_rnd_sum  = prod_reg + (PROD_W'(1) << (FRAC_GAIN - 1));
    assign alpha_rnd_sum = prod_reg + (PROD_W'(1) << (FRAC_ALPHA - 1));
    assign inc_rnd_sum   = prod_reg + PROD_W'(INC_HALF);

    // Proportional term.
    assign p_mag = gain_rnd_sum[FRAC_GAIN +: P_W-1];
    assign p_val = err_reg[ERR_W-1] ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});

    // Error difference for the raw derivative.
    assign diff_s   = (ERR_W+1)'(err_reg) - (ERR_W+1)'(prev_err_reg);
    assign diff_mag = diff_s[ERR_W] ? -diff_s : diff_s;

    // Raw derivative from the divider, saturated to DW bits.
    assign quot_x  = SAT_W'(div_rsp.quotient);
    assign raw_ovf = diff_neg_reg ? (quot_x > RAW_NEG_MAG) : (quot_x > RAW_POS_MAG);
    always_comb begin
        if (raw_ovf) begin
            raw_val = diff_neg_reg ? RAW_MIN : RAW_MAX;
        end else if (diff_neg_reg) begin
            raw_val = -$signed(DW'(div_rsp.quotient));
        end else begin
            raw_val = $signed(DW'(div_rsp.quotient));
        end
    end

    // First-order filter update, saturated to DW bits.
    assign filt_diff = (DW+1)'(raw_reg) - (DW+1)'(deriv_filt_reg);
    assign filt_mag  = filt_diff[DW] ? -filt_diff : filt_diff;
    assign filt_step = alpha_rnd_sum[FRAC_ALPHA +: DW+1];
    assign df_sum    = (DW+2)'(deriv_filt_reg)
                     + (filt_neg_reg ? -$signed({1'b0, filt_step}) : $signed({1'b0, filt_step}));
    assign df_ovf    = (df_sum[DW+1] != df_sum[DW]) || (df_sum[DW] != df_sum[DW-1]);
    assign df_val    = df_ovf ? (df_sum[DW+1] ? RAW_MIN : RAW_MAX) : df_sum[DW-1:0];

    // Derivative term.
    assign df_mag = deriv_filt_reg[DW-1] ? DW'(-deriv_filt_reg) : DW'(deriv_filt_reg);
    assign d_mag  = gain_rnd_sum[FRAC_GAIN +: D_W-1];
    assign d_val  = deriv_filt_reg[DW-1] ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});

    // Integral update: the clear flag drops the old value before the increment.
    assign inc_val    = err_reg[ERR_W-1] ? -$signed({1'b0, div_rsp.quotient[INC_W-2:0]})
                                         : $signed({1'b0, div_rsp.quotient[INC_W-2:0]});
    assign integ_base = clr_reg ? '0 : integ_acc_reg;
    assign acc_sum    = ACC_W'(integ_base) + ACC_W'(inc_val);
    always_comb begin
        if (acc_sum < ACC_W'(integ_min_reg)) begin
            integ_val = integ_min_reg;
        end else if (acc_sum > ACC_W'(integ_max_reg)) begin
            integ_val = integ_max_reg;
        end else begin
            integ_val = acc_sum[INTEG_W-1:0];
        end
    end

    // Output sum, formed at full width and clamped symmetrically.
    assign pid_sum = SUM_W'(p_reg) + SUM_W'(integ_acc_reg) + SUM_W'(d_reg);
    assign lim_pos = SUM_W'($signed({1'b0, out_limit_reg}));
    assign lim_neg = -lim_pos;
    always_comb begin
        if (pid_sum < lim_neg) begin
            out_val = lim_neg[OUT_W-1:0];
        end else if (pid_sum > lim_pos) begin
            out_val = lim_pos[OUT_W-1:0];
        end else begin
            out_val = pid_sum[OUT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next        = state_reg;
        err_next          = err_reg;
        err_mag_next      = err_mag_reg;
        dt_next           = dt_reg;
        clr_next          = clr_reg;
        diff_neg_next     = diff_neg_reg;
        filt_neg_next     = filt_neg_reg;
        mul_a_next        = mul_a_reg;
        mul_b_next        = mul_b_reg;
        p_next            = p_reg;
        d_next            = d_reg;
        raw_next          = raw_reg;
        inc_num_next      = inc_num_reg;
        integ_acc_next    = integ_acc_reg;
        prev_err_next     = prev_err_reg;
        deriv_filt_next   = deriv_filt_reg;
        m_valid_next      = m_valid_reg;
        m_correction_next = m_correction_reg;

        // Raw derivative: round(|diff| * 1000 / dt), the half divisor added first.
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg[DIVD_W-1:0] + DIVD_W'(dt_reg >> 1);
        div_req.divisor  = DIVS_W'(dt_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    err_next     = s_err_in;
                    err_mag_next = err_mag_in;
                    dt_next      = dt_in;
                    clr_next     = s_clear_integ;
                    mul_a_next   = MA_W'(err_mag_in);
                    mul_b_next   = MB_W'(gain_prop_reg);
                    state_next   = ST_P_MUL;
                end
            end
            ST_P_MUL: begin
                mul_a_next = MA_W'(gain_integ_reg);
                mul_b_next = MB_W'(dt_reg);
                state_next = ST_P_RND;
            end
            ST_P_RND: begin
                p_next        = p_val;
                diff_neg_next = diff_s[ERR_W];
                mul_a_next    = MA_W'(diff_mag);
                mul_b_next    = MB_W'(MS_PER_S);
                state_next    = ST_IGD;
            end
            ST_IGD: begin
                mul_a_next = MA_W'(err_mag_reg);
                mul_b_next = prod_reg[MB_W-1:0];
                state_next = ST_RAW_DIV;
            end
            ST_RAW_DIV: begin
                div_req.start = 1'b1;
                state_next    = ST_INC_NUM;
            end
            ST_INC_NUM: begin
                inc_num_next = inc_rnd_sum[INC_SHIFT +: DIVD_W];
                state_next   = ST_RAW_WAIT;
            end
            ST_RAW_WAIT: begin
                if (div_rsp.done) begin
                    raw_next         = raw_val;
                    div_req.start    = 1'b1;
                    div_req.dividend = inc_num_reg;
                    div_req.divisor  = DIVS_W'(MS_PER_S);
                    state_next       = ST_FILT_MUL;
                end
            end
            ST_FILT_MUL: begin
                filt_neg_next = filt_diff[DW];
                mul_a_next    = MA_W'(filt_mag);
                mul_b_next    = MB_W'(alpha_eff);
                state_next    = ST_FILT_WAIT;
            end
            ST_FILT_WAIT: begin
                state_next = ST_FILT_RND;
            end
            ST_FILT_RND: begin
                deriv_filt_next = df_val;
                state_next      = ST_D_MUL;
            end
            ST_D_MUL: begin
                mul_a_next = MA_W'(df_mag);
                mul_b_next = MB_W'(gain_deriv_reg);
                state_next = ST_D_WAIT;
            end
            ST_D_WAIT: begin
                state_next = ST_D_RND;
            end
            ST_D_RND: begin
                d_next     = d_val;
                state_next = ST_INC_WAIT;
            end
            ST_INC_WAIT: begin
                if (div_rsp.done) begin
                    integ_acc_next = integ_val;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_correction_next = out_val;
                    prev_err_next     = err_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        err_reg          <= err_next;
        err_mag_reg      <= err_mag_next;
        dt_reg           <= dt_next;
        clr_reg          <= clr_next;
        diff_neg_reg     <= diff_neg_next;
        filt_neg_reg     <= filt_neg_next;
        mul_a_reg        <= mul_a_next;
        mul_b_reg        <= mul_b_next;
        prod_reg         <= prod_next;
        p_reg            <= p_next;
        d_reg            <= d_next;
        raw_reg          <= raw_next;
        inc_num_reg      <= inc_num_next;
        m_correction_reg <= m_correction_next;

        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            integ_acc_reg  <= '0;
            prev_err_reg   <= '0;
            deriv_filt_reg <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            integ_acc_reg  <= integ_acc_next;
            prev_err_reg   <= prev_err_next;
            deriv_filt_reg <= deriv_filt_next;
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_correction = m_correction_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // With ordered limits, a freshly updated integral lies between them.
    ap_integ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(state_reg) == ST_INC_WAIT && $past(div_rsp.done)
            && $past(integ_min_reg) <= $past(integ_max_reg))
        |-> (integ_acc_reg >= $past(integ_min_reg) && integ_acc_reg <= $past(integ_max_reg)))
        else $error("integral outside its clamp after update");

    // A new result never exceeds the output limit in magnitude.
    ap_out_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg)
        |-> ($signed({m_correction_reg[OUT_W-1], m_correction_reg})
               <= $signed({2'b0, $past(out_limit_reg)})
            && $signed({m_correction_reg[OUT_W-1], m_correction_reg})
               >= -$signed({2'b0, $past(out_limit_reg)})))
        else $error("correction outside the output limit");

    // The divider only finishes while the sequencer waits for it.
    ap_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_RAW_WAIT || state_reg == ST_INC_WAIT))
        else $error("divider finished outside a wait state");

endmodule
